### src/cacf_pkg.sv
// Package for the two-dimensional cell-averaging CFAR pixel detector.
// Holds the shared widths, register codes, reset values and the pipeline struct.
// No dependencies; every other file but the checker imports it.
package cacf_pkg;

  localparam int WIDTH_MAX_DEF  = 2048;
  localparam int HEIGHT_MAX_DEF = 4096;
  localparam int HALF_MAX_DEF   = 15;

  localparam int PIX_W       = 8;
  localparam int Q_FRAC      = 12;
  localparam int IMG_W_W     = 12;
  localparam int IMG_H_W     = 13;
  localparam int HALF_W      = 4;
  localparam int TS_W        = 16;
  localparam int OUT_ROW_W   = 12;
  localparam int OUT_COL_W   = 11;
  localparam int OUT_DATA_W  = 1 + OUT_ROW_W + OUT_COL_W;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [PIX_W-1:0]   PIXEL_FLOOR = 8'd100;
  localparam logic [IMG_W_W-1:0] RST_WIDTH   = 12'd640;
  localparam logic [IMG_H_W-1:0] RST_HEIGHT  = 13'd480;
  localparam logic [HALF_W-1:0]  RST_BG_HALF = 4'd5;
  localparam logic [HALF_W-1:0]  RST_GD_HALF = 4'd1;
  localparam logic [TS_W-1:0]    RST_THRESH  = 16'd3686;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH      = 3'd0,
    REG_HEIGHT     = 3'd1,
    REG_BG_HALF    = 3'd2,
    REG_GUARD_HALF = 3'd3,
    REG_THRESH     = 3'd4
  } cfg_reg_t;

  // Bookkeeping that travels with every window step down the pipeline.
  typedef struct packed {
    logic                 virt;
    logic                 rstart;
    logic                 emit;
    logic                 last;
    logic [OUT_ROW_W-1:0] row;
    logic [OUT_COL_W-1:0] col;
  } step_t;

endpackage

### src/cacf_ctrl.sv
// Stream position tracking and window step issue for the CFAR detector.
// Counts rows and columns, inserts the trailing steps at each row end and
// drives the line store write and read. Depends on cacf_pkg.
module cacf_ctrl #(
  parameter int WIDTH_MAX  = cacf_pkg::WIDTH_MAX_DEF,
  parameter int HEIGHT_MAX = cacf_pkg::HEIGHT_MAX_DEF,
  parameter int HALF_MAX   = cacf_pkg::HALF_MAX_DEF,
  localparam int RING   = 2 * HALF_MAX + 1,
  localparam int RING_W = $clog2(RING),
  localparam int HW     = $clog2(HALF_MAX + 1),
  localparam int AW     = $clog2(WIDTH_MAX),
  localparam int CW     = $clog2(WIDTH_MAX + HALF_MAX + 1),
  localparam int RW     = $clog2(HEIGHT_MAX + HALF_MAX + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  adv,
  input  logic                  restart,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            in_pixel,
  input  logic                  in_flush,
  input  logic [CW-1:0]         eff_w,
  input  logic [RW-1:0]         eff_h,
  input  logic [HW-1:0]         eff_b,
  output logic                  mem_we,
  output logic [RING_W-1:0]     mem_bank,
  output logic [AW-1:0]         mem_addr,
  output logic [7:0]            mem_wdata,
  output logic                  mem_re,
  output logic                  s1_valid_r,
  output cacf_pkg::step_t       s1_step_r,
  output logic [7:0]            s1_pix_r,
  output logic [RING_W-1:0]     s1_ring_r,
  output logic [RING_W-1:0]     s1_rlim_r
);
  import cacf_pkg::*;

  logic [RW-1:0]     row_r, row_nxt, vrow_r, vrow_nxt, srow, jr;
  logic [CW-1:0]     col_r, col_nxt, vcol_r, vcol_nxt, scol, col_eff, cc;
  logic [RING_W-1:0] ring_r, ring_nxt;
  logic [HW-1:0]     drain_r, drain_nxt;
  logic              draining, accept, step_go;
  logic [7:0]        pix_eff;
  step_t             step;

  assign draining = (drain_r != '0);
  assign in_ready = adv && !draining;
  assign accept   = in_valid && in_ready;
  assign step_go  = adv && (draining || accept);
  assign col_eff  = (col_r >= eff_w) ? '0 : col_r;
  assign pix_eff  = (in_flush || row_r >= eff_h) ? '0 : in_pixel;

  // A trailing step at a row end judges one more column with zero columns entering.
  assign srow = draining ? vrow_r : row_r;
  assign scol = draining ? vcol_r : col_eff;
  assign jr   = srow - RW'(eff_b);
  assign cc   = scol - CW'(eff_b);

  always_comb begin
    step.virt   = draining;
    step.rstart = !draining && (col_eff == '0);
    step.emit   = (srow >= RW'(eff_b)) && (jr < eff_h) && (scol >= CW'(eff_b));
    step.last   = (jr == eff_h - 1'b1) && (cc == eff_w - 1'b1);
    step.row    = OUT_ROW_W'(jr);
    step.col    = OUT_COL_W'(cc);
  end

  always_comb begin
    row_nxt   = row_r;
    col_nxt   = col_r;
    ring_nxt  = ring_r;
    drain_nxt = drain_r;
    vrow_nxt  = vrow_r;
    vcol_nxt  = vcol_r;
    if (restart) begin
      row_nxt   = '0;
      col_nxt   = '0;
      ring_nxt  = '0;
      drain_nxt = '0;
    end else if (adv && draining) begin
      drain_nxt = drain_r - 1'b1;
      vcol_nxt  = vcol_r + 1'b1;
    end else if (accept) begin
      if (col_eff == eff_w - 1'b1) begin
        col_nxt   = '0;
        drain_nxt = eff_b;
        vrow_nxt  = row_r;
        vcol_nxt  = eff_w;
        if (row_r + 1'b1 >= eff_h + RW'(eff_b)) begin
          row_nxt  = '0;
          ring_nxt = '0;
        end else begin
          row_nxt  = row_r + 1'b1;
          ring_nxt = (ring_r == RING_W'(RING - 1)) ? '0 : ring_r + 1'b1;
        end
      end else begin
        col_nxt = col_eff + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r      <= '0;
      col_r      <= '0;
      ring_r     <= '0;
      drain_r    <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      ring_r  <= ring_nxt;
      drain_r <= drain_nxt;
      if (adv) begin
        s1_valid_r <= step_go;
      end
    end
  end

  always_ff @(posedge clk) begin
    vrow_r <= vrow_nxt;
    vcol_r <= vcol_nxt;
    if (adv) begin
      s1_step_r <= step;
      s1_pix_r  <= pix_eff;
      s1_ring_r <= ring_r;
      s1_rlim_r <= (row_r > RW'(RING - 1)) ? RING_W'(RING - 1) : RING_W'(row_r);
    end
  end

  assign mem_we    = accept;
  assign mem_bank  = ring_r;
  assign mem_addr  = col_eff[AW-1:0];
  assign mem_wdata = pix_eff;
  assign mem_re    = adv;

endmodule

### src/cacf_line_store.sv
// Line store for the CFAR detector: one bank per buffered row.
// Every bank is read at the same column while re is high; only the current row's
// bank is written. Depends on cacf_pkg.
module cacf_line_store #(
  parameter int WIDTH_MAX = cacf_pkg::WIDTH_MAX_DEF,
  parameter int HALF_MAX  = cacf_pkg::HALF_MAX_DEF,
  localparam int RING   = 2 * HALF_MAX + 1,
  localparam int RING_W = $clog2(RING),
  localparam int AW     = $clog2(WIDTH_MAX)
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [RING_W-1:0]         wbank,
  input  logic [AW-1:0]             addr,
  input  logic [7:0]                wdata,
  input  logic                      re,
  output logic [RING-1:0][7:0]      rd_data
);
  import cacf_pkg::*;

  for (genvar k = 0; k < RING; k++) begin : g_bank
    logic [PIX_W-1:0] bank_mem [WIDTH_MAX];
    logic [PIX_W-1:0] rd_q_r;

    always_ff @(posedge clk) begin
      if (we && (wbank == RING_W'(k))) begin
        bank_mem[addr] <= wdata;
      end
      if (re) begin
        rd_q_r <= bank_mem[addr];
      end
    end

    assign rd_data[k] = rd_q_r;
  end

endmodule

### src/cacf_col_sum.sv
// Vertical column sums for the CFAR detector.
// Aligns the line store read to window rows, masks rows outside the frame
// and the windows, and adds the column in a registered tree. Depends on cacf_pkg.
module cacf_col_sum #(
  parameter int HALF_MAX = cacf_pkg::HALF_MAX_DEF,
  localparam int RING   = 2 * HALF_MAX + 1,
  localparam int RING_W = $clog2(RING),
  localparam int HW     = $clog2(HALF_MAX + 1),
  localparam int CS_W   = $clog2(RING * 255 + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  adv,
  input  logic [HW-1:0]         eff_b,
  input  logic [HW-1:0]         guard_h,
  input  logic                  guard_ok,
  input  logic                  s1_valid,
  input  cacf_pkg::step_t       s1_step,
  input  logic [7:0]            s1_pix,
  input  logic [RING_W-1:0]     s1_ring,
  input  logic [RING_W-1:0]     s1_rlim,
  input  logic [RING-1:0][7:0]  rd_data,
  output logic                  s4_valid_r,
  output cacf_pkg::step_t       s4_step_r,
  output logic [CS_W-1:0]       s4_cs_r,
  output logic [CS_W-1:0]       s4_gs_r,
  output logic [7:0]            s4_ctr_r
);
  import cacf_pkg::*;

  localparam int NG   = (RING + 7) / 8;
  localparam int PS_W = $clog2(8 * 255 + 1);

  logic [RING_W-1:0]          sel [RING];
  logic [RING-1:0][PIX_W-1:0] pix_sel, px_nxt;
  logic [RING-1:0]            gm_nxt;
  logic [RING_W-1:0]          b_r, b2, g_lo, g_hi;
  logic [PIX_W-1:0]           ctr_nxt;

  logic                       s2_valid_r, s3_valid_r;
  step_t                      s2_step_r, s3_step_r;
  logic [RING-1:0][PIX_W-1:0] s2_px_r;
  logic [RING-1:0]            s2_gm_r;
  logic [PIX_W-1:0]           s2_ctr_r, s3_ctr_r;
  logic [NG-1:0][PS_W-1:0]    ps_nxt, pg_nxt, s3_ps_r, s3_pg_r;
  logic [CS_W-1:0]            cs_nxt, gs_nxt;

  assign b_r  = RING_W'(eff_b);
  assign b2   = RING_W'({eff_b, 1'b0});
  assign g_lo = guard_ok ? b_r - RING_W'(guard_h) : '0;
  assign g_hi = guard_ok ? b_r + RING_W'(guard_h) : '0;

  // Row offset d counts up from the current stream row; the newest row is the
  // beat itself, since its bank is being overwritten in the same cycle.
  always_comb begin
    for (int d = 0; d < RING; d++) begin
      sel[d] = (s1_ring >= RING_W'(d)) ? s1_ring - RING_W'(d)
                                       : s1_ring + RING_W'(RING - d);
      pix_sel[d] = (d == 0) ? s1_pix : rd_data[sel[d]];
      px_nxt[d]  = (!s1_step.virt && RING_W'(d) <= s1_rlim && RING_W'(d) <= b2)
                   ? pix_sel[d] : '0;
      gm_nxt[d]  = (RING_W'(d) >= g_lo) && (RING_W'(d) <= g_hi);
    end
    ctr_nxt = (!s1_step.virt && b_r <= s1_rlim) ? pix_sel[b_r] : '0;
  end

  always_comb begin
    for (int g = 0; g < NG; g++) begin
      ps_nxt[g] = '0;
      pg_nxt[g] = '0;
      for (int i = 0; i < 8; i++) begin
        if (g * 8 + i < RING) begin
          ps_nxt[g] = ps_nxt[g] + PS_W'(s2_px_r[g * 8 + i]);
          pg_nxt[g] = pg_nxt[g] + (s2_gm_r[g * 8 + i] ? PS_W'(s2_px_r[g * 8 + i]) : '0);
        end
      end
    end
  end

  always_comb begin
    cs_nxt = '0;
    gs_nxt = '0;
    for (int g = 0; g < NG; g++) begin
      cs_nxt = cs_nxt + CS_W'(s3_ps_r[g]);
      gs_nxt = gs_nxt + CS_W'(s3_pg_r[g]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid;
      s3_valid_r <= s2_valid_r;
      s4_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_step_r <= s1_step;
      s2_px_r   <= px_nxt;
      s2_gm_r   <= gm_nxt;
      s2_ctr_r  <= ctr_nxt;
      s3_step_r <= s2_step_r;
      s3_ps_r   <= ps_nxt;
      s3_pg_r   <= pg_nxt;
      s3_ctr_r  <= s2_ctr_r;
      s4_step_r <= s3_step_r;
      s4_cs_r   <= cs_nxt;
      s4_gs_r   <= gs_nxt;
      s4_ctr_r  <= s3_ctr_r;
    end
  end

endmodule

### src/cacf_window.sv
// Horizontal running sums for the CFAR detector.
// Keeps delay lines of column sums and centre pixels along the row and
// slides the background and guard window sums. Depends on cacf_pkg.
module cacf_window #(
  parameter int HALF_MAX = cacf_pkg::HALF_MAX_DEF,
  localparam int RING   = 2 * HALF_MAX + 1,
  localparam int RING_W = $clog2(RING),
  localparam int HW     = $clog2(HALF_MAX + 1),
  localparam int CS_W   = $clog2(RING * 255 + 1),
  localparam int WS_W   = $clog2(RING * RING * 255 + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic [HW-1:0]     eff_b,
  input  logic [HW-1:0]     guard_h,
  input  logic              guard_ok,
  input  logic              s4_valid,
  input  cacf_pkg::step_t   s4_step,
  input  logic [CS_W-1:0]   s4_cs,
  input  logic [CS_W-1:0]   s4_gs,
  input  logic [7:0]        s4_ctr,
  output logic              s5_valid_r,
  output cacf_pkg::step_t   s5_step_r,
  output logic [WS_W-1:0]   ws_r,
  output logic [WS_W-1:0]   gws_r,
  output logic [7:0]        p_r
);
  import cacf_pkg::*;

  logic [CS_W-1:0]  cs_line_r [RING];
  logic [CS_W-1:0]  gs_line_r [RING];
  logic [PIX_W-1:0] px_line_r [HALF_MAX + 1];
  logic [CS_W-1:0]  cs_line_nxt [RING];
  logic [CS_W-1:0]  gs_line_nxt [RING];
  logic [PIX_W-1:0] px_line_nxt [HALF_MAX + 1];
  logic [WS_W-1:0]  ws_nxt, gws_nxt;
  logic [PIX_W-1:0] p_nxt;
  logic [RING_W-1:0] i_bg, i_gadd, i_gsub;
  logic              upd;

  assign upd    = adv && s4_valid;
  assign i_bg   = RING_W'({eff_b, 1'b0});
  assign i_gadd = guard_ok ? RING_W'(eff_b) - RING_W'(guard_h) - 1'b1 : '0;
  assign i_gsub = guard_ok ? RING_W'(eff_b) + RING_W'(guard_h) : '0;

  // A row start drops everything left of column zero, which reads as zero.
  always_comb begin
    cs_line_nxt[0] = s4_cs;
    gs_line_nxt[0] = s4_gs;
    for (int k = 1; k < RING; k++) begin
      cs_line_nxt[k] = s4_step.rstart ? '0 : cs_line_r[k - 1];
      gs_line_nxt[k] = s4_step.rstart ? '0 : gs_line_r[k - 1];
    end
    px_line_nxt[0] = s4_ctr;
    for (int k = 1; k <= HALF_MAX; k++) begin
      px_line_nxt[k] = s4_step.rstart ? '0 : px_line_r[k - 1];
    end
    if (s4_step.rstart) begin
      ws_nxt  = WS_W'(s4_cs);
      gws_nxt = '0;
    end else begin
      ws_nxt  = ws_r + WS_W'(s4_cs) - WS_W'(cs_line_r[i_bg]);
      gws_nxt = gws_r + WS_W'(gs_line_r[i_gadd]) - WS_W'(gs_line_r[i_gsub]);
    end
    p_nxt = (eff_b == '0) ? s4_ctr : px_line_nxt[eff_b];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_valid_r <= 1'b0;
    end else if (adv) begin
      s5_valid_r <= s4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      cs_line_r <= cs_line_nxt;
      gs_line_r <= gs_line_nxt;
      px_line_r <= px_line_nxt;
      ws_r      <= ws_nxt;
      gws_r     <= gws_nxt;
      p_r       <= p_nxt;
    end
    if (adv) begin
      s5_step_r <= s4_step;
    end
  end

endmodule

### src/cacf_judge.sv
// Threshold decision and result register for the CFAR detector.
// Cross-multiplies pixel by cell count against threshold by window sum,
// then holds the result beat for the output channel. Depends on cacf_pkg.
module cacf_judge #(
  parameter int HALF_MAX = cacf_pkg::HALF_MAX_DEF,
  localparam int RING   = 2 * HALF_MAX + 1,
  localparam int HW     = $clog2(HALF_MAX + 1),
  localparam int WS_W   = $clog2(RING * RING * 255 + 1),
  localparam int CELL_W = $clog2(RING * RING + 1)
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            adv,
  input  logic [HW-1:0]                   eff_b,
  input  logic [HW-1:0]                   guard_h,
  input  logic                            guard_ok,
  input  logic [cacf_pkg::TS_W-1:0]       thresh,
  input  logic                            s5_valid,
  input  cacf_pkg::step_t                 s5_step,
  input  logic [WS_W-1:0]                 ws,
  input  logic [WS_W-1:0]                 gws,
  input  logic [7:0]                      p,
  output logic                            out_valid_r,
  output logic                            det_r,
  output logic [cacf_pkg::OUT_ROW_W-1:0]  row_r,
  output logic [cacf_pkg::OUT_COL_W-1:0]  col_r,
  output logic                            last_r
);
  import cacf_pkg::*;

  localparam int PP_W  = PIX_W + CELL_W;
  localparam int PT_W  = TS_W + WS_W;
  localparam int LHS_W = PP_W + Q_FRAC;
  localparam int CMP_W = (LHS_W > PT_W) ? LHS_W : PT_W;

  logic [CELL_W-1:0] side_b, side_g, cells;
  logic [WS_W-1:0]   s_diff;
  logic              s6_valid_r, s6_pass_r;
  step_t             s6_step_r;
  logic [PP_W-1:0]   s6_pp_r;
  logic [PT_W-1:0]   s6_pt_r;
  logic              det_nxt;

  assign side_b = CELL_W'({eff_b, 1'b1});
  assign side_g = CELL_W'({guard_h, 1'b1});
  assign cells  = side_b * side_b - side_g * side_g;
  assign s_diff = ws - gws;

  assign det_nxt = s6_pass_r &&
                   (CMP_W'({s6_pp_r, {Q_FRAC{1'b0}}}) > CMP_W'(s6_pt_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s6_valid_r  <= s5_valid;
      out_valid_r <= s6_valid_r && s6_step_r.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_step_r <= s5_step;
      s6_pass_r <= guard_ok && (p > PIXEL_FLOOR);
      s6_pp_r   <= PP_W'(p) * PP_W'(cells);
      s6_pt_r   <= PT_W'(thresh) * PT_W'(s_diff);
      det_r     <= det_nxt;
      row_r     <= s6_step_r.row;
      col_r     <= s6_step_r.col;
      last_r    <= s6_step_r.last;
    end
  end

endmodule

### src/ca_cfar_2d_pixel_detector_top.sv
// Two-dimensional cell-averaging CFAR detector, top level.
// Throughput: one pixel per cycle unless a result beat waits; each row end adds steps
// in which the trailing columns of the row are judged and no input beat is taken.
// Reset: synchronous, active low; the config registers return to defaults and the
// stream position to row 0, column 0. The line store needs no clearing.
module ca_cfar_2d_pixel_detector_top #(
  parameter int WIDTH_MAX  = cacf_pkg::WIDTH_MAX_DEF,
  parameter int HEIGHT_MAX = cacf_pkg::HEIGHT_MAX_DEF,
  parameter int HALF_MAX   = cacf_pkg::HALF_MAX_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [cacf_pkg::PIX_W-1:0]       in_tdata,   // pixel_value
  input  logic [0:0]                       in_tuser,   // flush
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [cacf_pkg::OUT_DATA_W-1:0]  out_tdata,  // detected, out_row, out_col
  output logic                             out_tlast,  // frame_last
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [cacf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cacf_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import cacf_pkg::*;

  localparam int RING   = 2 * HALF_MAX + 1;
  localparam int RING_W = $clog2(RING);
  localparam int HW     = $clog2(HALF_MAX + 1);
  localparam int AW     = $clog2(WIDTH_MAX);
  localparam int CW     = $clog2(WIDTH_MAX + HALF_MAX + 1);
  localparam int RW     = $clog2(HEIGHT_MAX + HALF_MAX + 1);
  localparam int CS_W   = $clog2(RING * 255 + 1);
  localparam int WS_W   = $clog2(RING * RING * 255 + 1);

  logic [IMG_W_W-1:0] width_r;
  logic [IMG_H_W-1:0] height_r;
  logic [HALF_W-1:0]  bg_half_r, guard_half_r;
  logic [TS_W-1:0]    thresh_r;
  logic               cfg_hit, adv;
  logic [CW-1:0]      eff_w;
  logic [RW-1:0]      eff_h;
  logic [HW-1:0]      eff_b, guard_h;
  logic               guard_ok;

  logic                  mem_we, mem_re;
  logic [RING_W-1:0]     mem_bank;
  logic [AW-1:0]         mem_addr;
  logic [7:0]            mem_wdata;
  logic [RING-1:0][7:0]  rd_data;

  logic              s1_valid, s4_valid, s5_valid, out_valid;
  step_t             s1_step, s4_step, s5_step;
  logic [7:0]        s1_pix, s4_ctr, p;
  logic [RING_W-1:0] s1_ring, s1_rlim;
  logic [CS_W-1:0]   s4_cs, s4_gs;
  logic [WS_W-1:0]   ws, gws;
  logic              det;
  logic [OUT_ROW_W-1:0] out_row;
  logic [OUT_COL_W-1:0] out_col;

  assign cfg_ready = 1'b1;

  always_comb begin
    unique case (cfg_reg_t'(cfg_index))
      REG_WIDTH, REG_HEIGHT, REG_BG_HALF, REG_GUARD_HALF, REG_THRESH: cfg_hit = cfg_valid;
      default: cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r      <= RST_WIDTH;
      height_r     <= RST_HEIGHT;
      bg_half_r    <= RST_BG_HALF;
      guard_half_r <= RST_GD_HALF;
      thresh_r     <= RST_THRESH;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_WIDTH:      width_r      <= cfg_data[IMG_W_W-1:0];
        REG_HEIGHT:     height_r     <= cfg_data[IMG_H_W-1:0];
        REG_BG_HALF:    bg_half_r    <= cfg_data[HALF_W-1:0];
        REG_GUARD_HALF: guard_half_r <= cfg_data[HALF_W-1:0];
        REG_THRESH:     thresh_r     <= cfg_data[TS_W-1:0];
        default: ;
      endcase
    end
  end

  // Out-of-range sizes are clamped into the range the hardware supports.
  always_comb begin
    if (width_r == '0) begin
      eff_w = CW'(1);
    end else if (32'(width_r) > 32'(WIDTH_MAX)) begin
      eff_w = CW'(WIDTH_MAX);
    end else begin
      eff_w = CW'(width_r);
    end
    if (height_r == '0) begin
      eff_h = RW'(1);
    end else if (32'(height_r) > 32'(HEIGHT_MAX)) begin
      eff_h = RW'(HEIGHT_MAX);
    end else begin
      eff_h = RW'(height_r);
    end
    eff_b    = (32'(bg_half_r) > 32'(HALF_MAX)) ? HW'(HALF_MAX) : HW'(bg_half_r);
    guard_ok = 32'(guard_half_r) < 32'(eff_b);
    guard_h  = HW'(guard_half_r);
  end

  // The whole pipeline moves together; it halts only when a result beat waits.
  assign adv = !out_valid || out_tready;

  cacf_ctrl #(
    .WIDTH_MAX(WIDTH_MAX), .HEIGHT_MAX(HEIGHT_MAX), .HALF_MAX(HALF_MAX)
  ) u_ctrl (
    .clk(clk), .rst_n(rst_n), .adv(adv), .restart(cfg_hit),
    .in_valid(in_tvalid), .in_ready(in_tready),
    .in_pixel(in_tdata), .in_flush(in_tuser[0]),
    .eff_w(eff_w), .eff_h(eff_h), .eff_b(eff_b),
    .mem_we(mem_we), .mem_bank(mem_bank), .mem_addr(mem_addr),
    .mem_wdata(mem_wdata), .mem_re(mem_re),
    .s1_valid_r(s1_valid), .s1_step_r(s1_step), .s1_pix_r(s1_pix),
    .s1_ring_r(s1_ring), .s1_rlim_r(s1_rlim)
  );

  cacf_line_store #(
    .WIDTH_MAX(WIDTH_MAX), .HALF_MAX(HALF_MAX)
  ) u_line_store (
    .clk(clk), .we(mem_we), .wbank(mem_bank), .addr(mem_addr),
    .wdata(mem_wdata), .re(mem_re), .rd_data(rd_data)
  );

  cacf_col_sum #(
    .HALF_MAX(HALF_MAX)
  ) u_col_sum (
    .clk(clk), .rst_n(rst_n), .adv(adv),
    .eff_b(eff_b), .guard_h(guard_h), .guard_ok(guard_ok),
    .s1_valid(s1_valid), .s1_step(s1_step), .s1_pix(s1_pix),
    .s1_ring(s1_ring), .s1_rlim(s1_rlim), .rd_data(rd_data),
    .s4_valid_r(s4_valid), .s4_step_r(s4_step),
    .s4_cs_r(s4_cs), .s4_gs_r(s4_gs), .s4_ctr_r(s4_ctr)
  );

  cacf_window #(
    .HALF_MAX(HALF_MAX)
  ) u_window (
    .clk(clk), .rst_n(rst_n), .adv(adv),
    .eff_b(eff_b), .guard_h(guard_h), .guard_ok(guard_ok),
    .s4_valid(s4_valid), .s4_step(s4_step),
    .s4_cs(s4_cs), .s4_gs(s4_gs), .s4_ctr(s4_ctr),
    .s5_valid_r(s5_valid), .s5_step_r(s5_step),
    .ws_r(ws), .gws_r(gws), .p_r(p)
  );

  cacf_judge #(
    .HALF_MAX(HALF_MAX)
  ) u_judge (
    .clk(clk), .rst_n(rst_n), .adv(adv),
    .eff_b(eff_b), .guard_h(guard_h), .guard_ok(guard_ok), .thresh(thresh_r),
    .s5_valid(s5_valid), .s5_step(s5_step), .ws(ws), .gws(gws), .p(p),
    .out_valid_r(out_valid), .det_r(det), .row_r(out_row), .col_r(out_col),
    .last_r(out_tlast)
  );

  assign out_tvalid = out_valid;
  assign out_tdata  = {out_col, out_row, det};

endmodule

### src/cacf_checker.sv
// Port-level checks for the CFAR detector top level, bound in below.
// Watches the result channel and the input back-pressure. Needs no package, only the top level.
module cacf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        out_tlast
);

  // A result beat that is not taken stays as it is.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result beat changed while stalled");

  // No result beat may come straight out of reset.
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // A stalled result halts the pipeline, so no pixel can be taken meanwhile.
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input taken while result stalled");

  // The pipeline holds still during a stall, so the frame end mark cannot appear then.
  a_last_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready && !out_tlast |=> !out_tlast)
    else $error("frame end mark appeared during a stall");

endmodule

bind ca_cfar_2d_pixel_detector_top cacf_checker u_checker (.*);

### dv/ca_cfar_2d_pixel_detector_top_tb.sv
// Self-checking testbench for the 2D cell-averaging CFAR pixel detector.
// Drives pixel beats and register writes, predicts every judged pixel and compares.
// Depends on cacf_pkg and ca_cfar_2d_pixel_detector_top.
module ca_cfar_2d_pixel_detector_top_tb;
  import cacf_pkg::*;

  localparam int RING = 2 * HALF_MAX_DEF + 1;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
  localparam int DRAIN_CYC = 60;
  localparam int N_ITEMS = 370;

  typedef struct packed {
    logic                 det;
    logic [OUT_ROW_W-1:0] row;
    logic [OUT_COL_W-1:0] col;
    logic                 last;
  } judged_px_t;

  typedef struct {
    logic [7:0] pix;
    bit         fl;
    bit         chk;
    bit         det;
  } dir_beat_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [PIX_W-1:0]      in_tdata = '0;
  logic [0:0]            in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  ca_cfar_2d_pixel_detector_top DUT (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: registers, stream position and the ring of recent rows.
  logic [7:0]  ring_px [0:RING-1][0:WIDTH_MAX_DEF-1];
  int unsigned reg_w, reg_h, reg_bg, reg_gd, reg_th;
  int unsigned pos_row, pos_col;
  judged_px_t  judged_q [$];
  int          errs = 0;
  int          n_items = 0;
  bit          gaps_on = 1'b1;
  bit          hold_req = 1'b0;
  bit          hold_done = 1'b0;
  int          dir_n = 0;
  judged_px_t  dir_first;

  function automatic int unsigned eff_w();
    if (reg_w == 0) return 1;
    return (reg_w > WIDTH_MAX_DEF) ? WIDTH_MAX_DEF : reg_w;
  endfunction

  function automatic int unsigned eff_h();
    if (reg_h == 0) return 1;
    return (reg_h > HEIGHT_MAX_DEF) ? HEIGHT_MAX_DEF : reg_h;
  endfunction

  function automatic int unsigned eff_bg();
    return (reg_bg > HALF_MAX_DEF) ? HALF_MAX_DEF : reg_bg;
  endfunction

  function automatic int unsigned pix_at(int r, int c, int w, int h);
    if (r < 0 || c < 0 || r >= h || c >= w) return 0;
    return ring_px[r % RING][c];
  endfunction

  // Cross-multiplied threshold test over the background ring outside the guard.
  function automatic bit cfar_judge(int r, int c, int w, int h, int b);
    int unsigned p, s, cells;
    int g;
    g = reg_gd;
    p = pix_at(r, c, w, h);
    if (p <= PIXEL_FLOOR || g >= b) return 1'b0;
    s = 0;
    for (int dr = -b; dr <= b; dr++)
      for (int dc = -b; dc <= b; dc++)
        if (!(dr >= -g && dr <= g && dc >= -g && dc <= g))
          s += pix_at(r + dr, c + dc, w, h);
    cells = (2 * b + 1) * (2 * b + 1) - (2 * g + 1) * (2 * g + 1);
    return (longint'(p) * cells * 4096) > (longint'(reg_th) * s);
  endfunction

  task automatic predict_pixels(input logic [7:0] pix, input bit fl);
    int unsigned w, h, b, v, jr, lo, hi;
    bit any;
    judged_px_t e;
    w = eff_w();
    h = eff_h();
    b = eff_bg();
    v = (fl || pos_row >= h) ? 0 : pix;
    if (pos_col >= w) pos_col = 0;
    ring_px[pos_row % RING][pos_col] = v[7:0];
    if (pos_row >= b && pos_row - b < h) begin
      jr = pos_row - b;
      any = 1'b1;
      lo = 0;
      hi = 0;
      if (pos_col == w - 1) begin
        lo = (pos_col >= b) ? pos_col - b : 0;
        hi = w - 1;
      end else if (pos_col >= b) begin
        lo = pos_col - b;
        hi = lo;
      end else begin
        any = 1'b0;
      end
      if (any)
        for (int unsigned c = lo; c <= hi; c++) begin
          e.det  = cfar_judge(jr, c, w, h, b);
          e.row  = jr[OUT_ROW_W-1:0];
          e.col  = c[OUT_COL_W-1:0];
          e.last = (jr == h - 1 && c == w - 1);
          judged_q.push_back(e);
        end
    end
    pos_col++;
    if (pos_col >= w) begin
      pos_col = 0;
      pos_row++;
      if (pos_row >= h + b) pos_row = 0;
    end
  endtask

  // The first result a beat causes is kept aside for the directed checks.
  task automatic send_pixel(input logic [7:0] pix, input bit fl);
    int qn;
    if (n_items >= N_ITEMS - 70) gaps_on = 1'b0;
    if (gaps_on && $urandom_range(0, 9) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = pix;
    in_tuser  = fl;
    do @(posedge clk); while (!in_tready);
    qn = judged_q.size();
    predict_pixels(pix, fl);
    dir_n = judged_q.size() - qn;
    if (dir_n > 0) dir_first = judged_q[qn];
    n_items++;
    @(negedge clk);
  endtask

  // Register writes only once the block has drained.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    in_tvalid = 1'b0;
    wait (judged_q.size() == 0);
    repeat (DRAIN_CYC) @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val[CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_WIDTH:      reg_w  = val & 32'hFFF;
      REG_HEIGHT:     reg_h  = val & 32'h1FFF;
      REG_BG_HALF:    reg_bg = val & 32'hF;
      REG_GUARD_HALF: reg_gd = val & 32'hF;
      REG_THRESH:     reg_th = val & 32'hFFFF;
      default: ;
    endcase
    if (idx <= REG_THRESH) begin
      pos_row = 0;
      pos_col = 0;
    end
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_all(input int unsigned w, h, bg, gd, th);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_BG_HALF, bg);
    write_reg(REG_GUARD_HALF, gd);
    write_reg(REG_THRESH, th);
  endtask

  // One frame in raster order followed by its pad rows; may be cut short.
  task automatic run_frame(input bit cut);
    int unsigned w, h, b, rows, stop_at, k;
    logic [7:0] p;
    bit fl;
    w = eff_w();
    h = eff_h();
    b = eff_bg();
    rows = h + b;
    stop_at = cut ? $urandom_range(1, w * rows) : w * rows;
    k = 0;
    for (int unsigned r = 0; r < rows; r++)
      for (int unsigned c = 0; c < w; c++) begin
        if (k >= stop_at || n_items >= N_ITEMS) return;
        if (r < h) begin
          p  = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(101, 255))
                                            : 8'($urandom_range(0, 120));
          fl = ($urandom_range(0, 29) == 0);
        end else begin
          fl = ($urandom_range(0, 19) != 0);
          p  = fl ? 8'd0 : 8'($urandom_range(0, 255));
        end
        send_pixel(p, fl);
        k++;
      end
  endtask

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    @(negedge clk);
    forever begin
      if (hold_req) begin
        out_tready = 1'b0;
        repeat (400) @(negedge clk);
        hold_req = 1'b0;
      end else if (gaps_on && $urandom_range(0, 11) == 0) begin
        out_tready = 1'b0;
        repeat ($urandom_range(1, 17)) @(negedge clk);
      end else begin
        out_tready = 1'b1;
        @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    judged_px_t got, e;
    if (rst_n && out_tvalid && out_tready) begin
      got.det  = out_tdata[0];
      got.row  = out_tdata[OUT_ROW_W:1];
      got.col  = out_tdata[OUT_DATA_W-1:OUT_ROW_W+1];
      got.last = out_tlast;
      if (judged_q.size() == 0) begin
        $error("unexpected result beat row %0d col %0d", got.row, got.col);
        errs++;
      end else begin
        e = judged_q.pop_front();
        if (got.det !== e.det) begin
          $error("detected: expected %0d, actual %0d", e.det, got.det); errs++;
        end
        if (got.row !== e.row) begin
          $error("out_row: expected %0d, actual %0d", e.row, got.row); errs++;
        end
        if (got.col !== e.col) begin
          $error("out_col: expected %0d, actual %0d", e.col, got.col); errs++;
        end
        if (got.last !== e.last) begin
          $error("frame_last: expected %0d, actual %0d", e.last, got.last); errs++;
        end
      end
    end
  end

  initial begin
    #20000000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Two 3x2 frames, window 3x3 with no guard: bright isolated pixels, the
  // floor value, a pad beat inside the image and data beats in the pad rows.
  dir_beat_t dir_tab [18] = '{
    '{8'd200, 1'b0, 1'b0, 1'b0}, '{8'd0, 1'b0, 1'b0, 1'b0}, '{8'd0, 1'b0, 1'b0, 1'b0},
    '{8'd0,   1'b0, 1'b0, 1'b0}, '{8'd0, 1'b0, 1'b1, 1'b1}, '{8'd0, 1'b0, 1'b1, 1'b0},
    '{8'd0,   1'b1, 1'b1, 1'b0}, '{8'd0, 1'b1, 1'b0, 1'b0}, '{8'd0, 1'b1, 1'b1, 1'b0},
    '{8'd101, 1'b0, 1'b0, 1'b0}, '{8'd100, 1'b0, 1'b0, 1'b0}, '{8'd255, 1'b1, 1'b0, 1'b0},
    '{8'd0,   1'b0, 1'b0, 1'b0}, '{8'd0, 1'b0, 1'b1, 1'b1}, '{8'd0, 1'b0, 1'b1, 1'b0},
    '{8'd255, 1'b0, 1'b1, 1'b0}, '{8'd255, 1'b0, 1'b0, 1'b0}, '{8'd255, 1'b0, 1'b1, 1'b0}
  };

  initial begin
    int unsigned w, h, bg, gd, th;
    reg_w   = RST_WIDTH;
    reg_h   = RST_HEIGHT;
    reg_bg  = RST_BG_HALF;
    reg_gd  = RST_GD_HALF;
    reg_th  = RST_THRESH;
    pos_row = 0;
    pos_col = 0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // A few beats at the reset settings before anything is written.
    for (int i = 0; i < 8; i++) send_pixel(8'($urandom_range(0, 255)), 1'b0);

    set_all(3, 2, 1, 0, 4096);
    foreach (dir_tab[i]) begin
      send_pixel(dir_tab[i].pix, dir_tab[i].fl);
      if (dir_tab[i].chk && dir_n > 0 && dir_first.det !== dir_tab[i].det) begin
        $error("detected: expected %0d, actual %0d (directed)", dir_tab[i].det, dir_first.det);
        errs++;
      end
    end

    // Register extremes: sizes out of range, 1x1 window, widest guard and threshold.
    set_all(0, 8191, 0, 0, 65535);
    for (int i = 0; i < 20; i++)
      send_pixel(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    set_all(4095, 0, 15, 14, 0);
    for (int i = 0; i < 30; i++) send_pixel(8'($urandom_range(0, 255)), 1'b0);
    write_reg(REG_SPARE, $urandom_range(0, 65535));
    set_all(3, 2, 15, 14, 0);
    run_frame(1'b0);
    set_all(2, 3, 2, 15, 65535);
    run_frame(1'b0);

    while (n_items < N_ITEMS) begin
      w  = ($urandom_range(0, 5) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      h  = $urandom_range(1, 8);
      bg = ($urandom_range(0, 5) == 0) ? $urandom_range(5, 15) : $urandom_range(1, 4);
      gd = ($urandom_range(0, 6) == 0) ? $urandom_range(bg, 15) : $urandom_range(0, bg - 1);
      case ($urandom_range(0, 5))
        0: th = 0;
        1: th = 65535;
        default: th = $urandom_range(1000, 12000);
      endcase
      if ($urandom_range(0, 3) == 0) write_reg(REG_SPARE, $urandom_range(0, 65535));
      set_all(w, h, bg, gd, th);
      if (n_items > 120 && !hold_done) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      run_frame($urandom_range(0, 7) == 0);
      if ($urandom_range(0, 2) == 0) begin
        in_tvalid = 1'b0;
        wait (judged_q.size() == 0);
        @(negedge clk);
      end
      run_frame(1'b0);
    end

    in_tvalid = 1'b0;
    wait (judged_q.size() == 0);
    repeat (DRAIN_CYC) @(negedge clk);
    if (errs == 0 && judged_q.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
